// File: rtl/core/kptmm_pkg.sv
`default_nettype none

package kptmm_pkg;

    localparam int DATA_W = 32;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } kptmm_cmd_t;

    typedef struct packed {
        logic at_count;
        logic out_free;
    } kptmm_status_t;

endpackage

`default_nettype wire

// File: rtl/core/kptmm_ram.sv
`default_nettype none

module kptmm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/kptmm_ctrl.sv
`default_nettype none

module kptmm_ctrl
    import kptmm_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire kptmm_status_t status,
    output kptmm_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;

    always_comb
    begin
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.load      = 1'b1;
                    state_next    = ST_SCAN;
                    in_ready_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (status.at_count)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit    = 1'b1;
                    state_next    = ST_IDLE;
                    in_ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;

endmodule

`default_nettype wire

// File: rtl/core/kptmm_datapath.sv
`default_nettype none

module kptmm_datapath
    import kptmm_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire kptmm_cmd_t        cmd,
    output kptmm_status_t          status,
    input  wire logic [DATA_W-1:0] timestamp,
    input  wire logic [DATA_W-1:0] price,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [DATA_W-1:0] current_price,
    output logic      [DATA_W-1:0] max_price,
    output logic      [DATA_W-1:0] min_price,
    output logic                   table_full
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

    logic [DATA_W-1:0] ts_reg, ts_next;
    logic [DATA_W-1:0] pr_reg, pr_next;
    logic [DATA_W-1:0] latest_reg, latest_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [AW-1:0]     rd_tag_reg, rd_tag_next;
    logic              hit_reg, hit_next;
    logic [AW-1:0]     hit_idx_reg, hit_idx_next;
    logic [DATA_W-1:0] cur_reg, cur_next;
    logic [DATA_W-1:0] hi_reg, hi_next;
    logic [DATA_W-1:0] lo_reg, lo_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_cur_reg, out_cur_next;
    logic [DATA_W-1:0] out_hi_reg, out_hi_next;
    logic [DATA_W-1:0] out_lo_reg, out_lo_next;
    logic              out_full_reg, out_full_next;

    logic [2*DATA_W-1:0] rd_data;
    logic [DATA_W-1:0]   rd_key;
    logic [DATA_W-1:0]   rd_price;
    logic                accepted;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;

    kptmm_ram #(
        .WIDTH(2 * DATA_W),
        .DEPTH(ENTRIES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata({ts_reg, pr_reg}),
        .raddr(idx_reg[AW-1:0]),
        .rdata(rd_data)
    );

    assign rd_key   = rd_data[2*DATA_W-1:DATA_W];
    assign rd_price = rd_data[DATA_W-1:0];

    // A new key is taken when it already has a slot or a slot is still free.
    assign accepted  = hit_reg || (count_reg != FULL_COUNT);
    assign ram_we    = cmd.commit && accepted;
    assign ram_waddr = hit_reg ? hit_idx_reg : count_reg[AW-1:0];

    always_comb
    begin
        ts_next        = ts_reg;
        pr_next        = pr_reg;
        latest_next    = latest_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rd_valid_next  = cmd.step;
        rd_tag_next    = idx_reg[AW-1:0];
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        cur_next       = cur_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_cur_next   = out_cur_reg;
        out_hi_next    = out_hi_reg;
        out_lo_next    = out_lo_reg;
        out_full_next  = out_full_reg;

        if (cmd.load)
        begin
            ts_next  = timestamp;
            pr_next  = price;
            idx_next = '0;
            hit_next = 1'b0;
            cur_next = '0;
            hi_next  = '0;
            lo_next  = '1;
        end

        if (cmd.step)
        begin
            idx_next = idx_reg + CW'(1);
        end

        // The slot that holds the incoming key is left out here, since its
        // price is replaced by the new one at commit.
        if (rd_valid_reg)
        begin
            if (rd_key == ts_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = rd_tag_reg;
            end
            else
            begin
                if (rd_key == latest_reg)
                begin
                    cur_next = rd_price;
                end
                if (rd_price > hi_reg)
                begin
                    hi_next = rd_price;
                end
                if (rd_price < lo_reg)
                begin
                    lo_next = rd_price;
                end
            end
        end

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
            out_full_next  = !accepted;
            out_cur_next   = cur_reg;
            out_hi_next    = hi_reg;
            out_lo_next    = lo_reg;
            if (accepted)
            begin
                if (ts_reg > latest_reg)
                begin
                    latest_next = ts_reg;
                end
                if (ts_reg >= latest_reg)
                begin
                    out_cur_next = pr_reg;
                end
                if (pr_reg > hi_reg)
                begin
                    out_hi_next = pr_reg;
                end
                if (pr_reg < lo_reg)
                begin
                    out_lo_next = pr_reg;
                end
                if (!hit_reg)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latest_reg    <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            latest_reg    <= latest_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ts_reg      <= ts_next;
        pr_reg      <= pr_next;
        rd_tag_reg  <= rd_tag_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
        cur_reg     <= cur_next;
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        out_cur_reg <= out_cur_next;
        out_hi_reg  <= out_hi_next;
        out_lo_reg  <= out_lo_next;
        out_full_reg <= out_full_next;
    end

    assign status.at_count = (idx_reg == count_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign current_price = out_cur_reg;
    assign max_price     = out_hi_reg;
    assign min_price     = out_lo_reg;
    assign table_full    = out_full_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("fill count exceeds table depth");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> idx_reg < count_reg)
        else $error("read issued beyond filled slots");

    a_drop_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && !accepted |=> count_reg == $past(count_reg) && table_full)
        else $error("dropped update changed the table");

    a_commit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !out_valid_reg || out_ready)
        else $error("result overwritten before delivery");
`endif

endmodule

`default_nettype wire

// File: rtl/core/keyed_price_table_min_max_core.sv
// Channel   Handshake             Beat fields
// input     in_valid / in_ready   timestamp, price
// output    out_valid / out_ready current_price, max_price, min_price, table_full
//
// An update scans every filled slot, one slot per cycle, through the single
// read port of the slot memory, then commits once the output register is free.
// Reset clears the fill count and the latest timestamp; no memory clearing pass.
// A finished result waits in the output register while the next update is taken.
`default_nettype none

module keyed_price_table_min_max_core
    import kptmm_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] timestamp,
    input  wire logic [DATA_W-1:0] price,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [DATA_W-1:0] current_price,
    output logic      [DATA_W-1:0] max_price,
    output logic      [DATA_W-1:0] min_price,
    output logic                   table_full
);

    kptmm_cmd_t    cmd;
    kptmm_status_t status;

    kptmm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .status  (status),
        .cmd     (cmd)
    );

    kptmm_datapath #(
        .ENTRIES(ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .timestamp    (timestamp),
        .price        (price),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .current_price(current_price),
        .max_price    (max_price),
        .min_price    (min_price),
        .table_full   (table_full)
    );

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kptmm_pkg::*;

    localparam int SLOTS = 64;
    localparam int RANDOM_UPDATES = 2000;
    localparam int CALM_TAIL = 150;

    typedef struct packed {
        logic [DATA_W-1:0] ts;
        logic [DATA_W-1:0] pr;
    } update_t;

    typedef struct packed {
        logic [DATA_W-1:0] cur;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] lo;
        logic              full;
    } quote_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [DATA_W-1:0] timestamp = '0;
    logic [DATA_W-1:0] price = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [DATA_W-1:0] current_price;
    logic [DATA_W-1:0] max_price;
    logic [DATA_W-1:0] min_price;
    logic              table_full;

    keyed_price_table_min_max_core #(
        .ENTRIES(SLOTS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .timestamp    (timestamp),
        .price        (price),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .current_price(current_price),
        .max_price    (max_price),
        .min_price    (min_price),
        .table_full   (table_full)
    );

    always #4 clk = ~clk;

    update_t           pending_updates[$];
    quote_t            expected_quotes[$];
    logic              in_fire = 1'b0;
    int                in_gap = 0;
    int                out_gap = 0;
    int                mismatch_count = 0;

    logic [DATA_W-1:0] book_key[SLOTS];
    logic [DATA_W-1:0] book_price[SLOTS];
    bit                book_live[SLOTS];
    logic [DATA_W-1:0] newest_time = '0;

    logic [DATA_W-1:0] stored_keys[$];
    bit                key_stored[logic [DATA_W-1:0]];
    logic [DATA_W-1:0] top_key = '0;

    function automatic quote_t apply_update(update_t u);
        int     slot = -1;
        bit     any = 1'b0;
        quote_t q = '0;
        for (int i = 0; i < SLOTS; i++)
            if (slot < 0 && book_live[i] && book_key[i] == u.ts)
                slot = i;
        if (slot < 0) begin
            for (int i = 0; i < SLOTS; i++)
                if (slot < 0 && !book_live[i])
                    slot = i;
            if (slot >= 0) begin
                book_live[slot] = 1'b1;
                book_key[slot] = u.ts;
            end
        end
        if (slot >= 0) begin
            book_price[slot] = u.pr;
            if (u.ts > newest_time)
                newest_time = u.ts;
        end else begin
            q.full = 1'b1;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (book_live[i]) begin
                if (book_key[i] == newest_time)
                    q.cur = book_price[i];
                if (!any) begin
                    q.hi = book_price[i];
                    q.lo = book_price[i];
                    any = 1'b1;
                end else begin
                    if (book_price[i] > q.hi)
                        q.hi = book_price[i];
                    if (book_price[i] < q.lo)
                        q.lo = book_price[i];
                end
            end
        end
        return q;
    endfunction

    function automatic logic [DATA_W-1:0] pick_price();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return DATA_W'($urandom_range(0, 1000));
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic queue_update(logic [DATA_W-1:0] ts, logic [DATA_W-1:0] pr);
        if (!key_stored.exists(ts) && stored_keys.size() < SLOTS) begin
            key_stored[ts] = 1'b1;
            stored_keys.push_back(ts);
            if (ts > top_key)
                top_key = ts;
        end
        pending_updates.push_back('{ts: ts, pr: pr});
    endtask

    always @(negedge clk) begin : drive
        bit      calm;
        logic    nxt_valid;
        update_t nxt;
        nxt_valid = in_valid;
        nxt = '{ts: timestamp, pr: price};
        calm = pending_updates.size() < CALM_TAIL || (pending_updates.size() / 250) % 3 == 1;
        if (rst_n) begin
            if (!in_valid || in_fire) begin
                if (in_gap == 0 && !calm && $urandom_range(0, 5) == 0)
                    in_gap = $urandom_range(1, 12);
                if (in_gap != 0) begin
                    in_gap--;
                    nxt_valid = 1'b0;
                end else if (pending_updates.size() != 0) begin
                    nxt = pending_updates.pop_front();
                    nxt_valid = 1'b1;
                end else begin
                    nxt_valid = 1'b0;
                end
            end
            if (out_gap == 0 && !calm && $urandom_range(0, 5) == 0)
                out_gap = $urandom_range(1, 12);
            if (out_gap != 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
        in_valid <= nxt_valid;
        timestamp <= nxt.ts;
        price <= nxt.pr;
    end

    always @(posedge clk) begin : watch
        quote_t want;
        quote_t got;
        bit     bad;
        in_fire <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            expected_quotes.push_back(apply_update('{ts: timestamp, pr: price}));
        if (rst_n && out_valid && out_ready) begin
            got = '{cur: current_price, hi: max_price, lo: min_price, full: table_full};
            if (expected_quotes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: cur=%h max=%h min=%h full=%b",
                             got.cur, got.hi, got.lo, got.full);
            end else begin
                want = expected_quotes.pop_front();
                bad = got.cur !== want.cur || got.hi !== want.hi ||
                      got.lo !== want.lo || got.full !== want.full;
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected cur=%h max=%h min=%h full=%b, got cur=%h max=%h min=%h full=%b",
                                 want.cur, want.hi, want.lo, want.full,
                                 got.cur, got.hi, got.lo, got.full);
                end
            end
        end
    end

    initial begin : stimulus
        int                r;
        int                new_odds;
        logic [DATA_W-1:0] ts;

        queue_update('0, '0);
        queue_update('0, '1);
        queue_update('1, 32'h1234_5678);
        queue_update(32'd5, 32'd1);
        queue_update('1, '1);
        queue_update(32'hAAAA_AAAA, 32'h5555_5555);
        queue_update(32'h5555_5555, 32'hAAAA_AAAA);
        queue_update(32'd5, '0);
        queue_update(32'h8000_0000, 32'h8000_0000);
        queue_update(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_update('1, 32'd7);
        queue_update(32'd6, '1);

        repeat (RANDOM_UPDATES) begin
            r = $urandom_range(0, 99);
            new_odds = (stored_keys.size() < SLOTS) ? 60 : 30;
            if (r < new_odds)
                ts = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom_range(0, 4095))
                                                 : DATA_W'($urandom);
            else if (r < new_odds + 8)
                ts = top_key;
            else if (r < new_odds + 13)
                ts = stored_keys[$urandom_range(0, stored_keys.size() - 1)] + 1'b1;
            else
                ts = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            queue_update(ts, pick_price());
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_updates.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_quotes.size() != 0)
            @(posedge clk);
        repeat (4 * SLOTS) @(posedge clk);

        if (mismatch_count == 0 && expected_quotes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
